FILE: hw/rtl/dkcl_pkg.sv
// Shared types and constants of the descriptor key cache lookup block.
// Used by dkcl_ctrl, dkcl_dp and descriptor_key_cache_lookup_top; no dependencies.
package dkcl_pkg;

	localparam int TABLE_DEPTH_DEF  = 256;
	localparam int RECENT_DEPTH_DEF = 5;
	localparam int MASK_W           = 64;
	localparam int KEY_W            = 4 * MASK_W;
	localparam int SLOT_W           = 8;
	localparam int OUTCOME_W        = 2;

	localparam logic [OUTCOME_W-1:0] OUTCOME_RECENT = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUTCOME_TABLE  = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUTCOME_ALLOC  = 2'd2;
	localparam logic [OUTCOME_W-1:0] OUTCOME_FULL   = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic load_key;    // latch key, clear both scan indexes
		logic rd_recent;   // read key store at recent entry addressed by recent index
		logic rd_table;    // read key store at table index
		logic inc_recent;
		logic inc_table;
		logic recent_hit;  // swap hit entry with front, record result
		logic table_hit;   // promote table index to front, record result
		logic alloc;       // write key at fill count, record result
		logic set_full;    // record full result
		logic out_load;    // move recorded result into output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic match;         // registered read data equals key
		logic recent_used;   // addressed recent entry is valid
		logic recent_last;   // recent index at last entry
		logic table_done;    // table index reached fill count
		logic full;          // no free slot
		logic out_free;      // output register can take a result
	} sts_t;

endpackage

FILE: hw/rtl/dkcl_ctrl.sv
// Lookup sequencer: walks recent list, table scan, allocation, result hand-off.
// Depends on dkcl_pkg (cmd_t, sts_t).
module dkcl_ctrl
	import dkcl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_R_CHK,
		ST_R_CMP,
		ST_T_CHK,
		ST_T_CMP,
		ST_ALLOC,
		ST_FIN
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_key = 1'b1;
					state_d      = ST_R_CHK;
				end
			end
			ST_R_CHK: begin
				if (sts.recent_used) begin
					cmd.rd_recent = 1'b1;
					state_d       = ST_R_CMP;
				end else if (sts.recent_last) begin
					state_d = ST_T_CHK;
				end else begin
					cmd.inc_recent = 1'b1;
				end
			end
			ST_R_CMP: begin
				if (sts.match) begin
					cmd.recent_hit = 1'b1;
					state_d        = ST_FIN;
				end else if (sts.recent_last) begin
					state_d = ST_T_CHK;
				end else begin
					cmd.inc_recent = 1'b1;
					state_d        = ST_R_CHK;
				end
			end
			ST_T_CHK: begin
				if (sts.table_done) begin
					state_d = ST_ALLOC;
				end else begin
					cmd.rd_table = 1'b1;
					state_d      = ST_T_CMP;
				end
			end
			ST_T_CMP: begin
				if (sts.match) begin
					cmd.table_hit = 1'b1;
					state_d       = ST_FIN;
				end else begin
					cmd.inc_table = 1'b1;
					state_d       = ST_T_CHK;
				end
			end
			ST_ALLOC: begin
				if (sts.full) begin
					cmd.set_full = 1'b1;
				end else begin
					cmd.alloc = 1'b1;
				end
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/dkcl_dp.sv
// Datapath: key register, key store memory, recent list, fill count, result regs.
// Depends on dkcl_pkg (cmd_t, sts_t, widths, outcome codes).
module dkcl_dp
	import dkcl_pkg::*;
#(
	parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
	parameter int RECENT_DEPTH = RECENT_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [MASK_W-1:0]    mask_full,
	input  logic [MASK_W-1:0]    mask_multistream,
	input  logic [MASK_W-1:0]    mask_interleaved,
	input  logic [MASK_W-1:0]    mask_instanced,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SLOT_W-1:0]    slot,
	output logic [OUTCOME_W-1:0] outcome
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int RI_W  = $clog2(RECENT_DEPTH);

	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] mem_q [TABLE_DEPTH];
	logic [KEY_W-1:0] rdata_s1;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] tidx_q;
	logic [RI_W-1:0]  ridx_q;

	logic          rused_q [RECENT_DEPTH];
	logic [AW-1:0] rslot_q [RECENT_DEPTH];

	logic [AW-1:0]        res_idx_q;
	logic [OUTCOME_W-1:0] res_out_q;

	logic                 out_valid_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [OUTCOME_W-1:0] outcome_q;

	logic [AW-1:0]        raddr;
	logic [AW-1:0]        hit_slot;
	logic [AW+SLOT_W-1:0] slot_ext;

	assign hit_slot = rslot_q[ridx_q];
	assign raddr    = cmd.rd_recent ? hit_slot : tidx_q[AW-1:0];
	assign slot_ext = {{SLOT_W{1'b0}}, res_idx_q};

	assign sts.match       = (rdata_s1 == key_q);
	assign sts.recent_used = rused_q[ridx_q];
	assign sts.recent_last = (ridx_q == RI_W'(RECENT_DEPTH - 1));
	assign sts.table_done  = (tidx_q >= count_q);
	assign sts.full        = (count_q == CNT_W'(TABLE_DEPTH));
	assign sts.out_free    = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign slot      = slot_q;
	assign outcome   = outcome_q;

	// key store, no reset; only slots below the fill count are ever read
	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			mem_q[count_q[AW-1:0]] <= key_q;
		end
		if (cmd.rd_recent || cmd.rd_table) begin
			rdata_s1 <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			key_q <= {mask_full, mask_multistream, mask_interleaved, mask_instanced};
		end
		if (cmd.recent_hit) begin
			res_idx_q <= hit_slot;
			res_out_q <= OUTCOME_RECENT;
		end else if (cmd.table_hit) begin
			res_idx_q <= tidx_q[AW-1:0];
			res_out_q <= OUTCOME_TABLE;
		end else if (cmd.alloc) begin
			res_idx_q <= count_q[AW-1:0];
			res_out_q <= OUTCOME_ALLOC;
		end else if (cmd.set_full) begin
			res_idx_q <= '0;
			res_out_q <= OUTCOME_FULL;
		end
		if (cmd.out_load) begin
			slot_q    <= slot_ext[SLOT_W-1:0];
			outcome_q <= res_out_q;
		end
		// swap on recent hit, promote on table hit
		if (cmd.recent_hit) begin
			rslot_q[ridx_q] <= rslot_q[0];
			rslot_q[0]      <= hit_slot;
		end else if (cmd.table_hit) begin
			for (int k = 1; k < RECENT_DEPTH; k++) begin
				rslot_q[k] <= rslot_q[0];
			end
			rslot_q[0] <= tidx_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			tidx_q      <= '0;
			ridx_q      <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < RECENT_DEPTH; k++) begin
				rused_q[k] <= 1'b0;
			end
		end else begin
			if (cmd.load_key) begin
				tidx_q <= '0;
				ridx_q <= '0;
			end else begin
				if (cmd.inc_table) begin
					tidx_q <= tidx_q + 1'b1;
				end
				if (cmd.inc_recent) begin
					ridx_q <= ridx_q + 1'b1;
				end
			end
			if (cmd.alloc) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.recent_hit) begin
				rused_q[ridx_q] <= rused_q[0];
				rused_q[0]      <= 1'b1;
			end else if (cmd.table_hit) begin
				for (int k = 1; k < RECENT_DEPTH; k++) begin
					rused_q[k] <= rused_q[0];
				end
				rused_q[0] <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count above table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.alloc |=> count_q == $past(count_q))
		else $error("fill count moved without allocation");

	a_front_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.recent_hit || cmd.table_hit) |=> rused_q[0])
		else $error("front entry invalid after hit");

	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> !sts.full)
		else $error("allocation into full table");

endmodule

FILE: hw/rtl/descriptor_key_cache_lookup_top.sv
// Top level of the descriptor key cache lookup block.
// Depends on dkcl_pkg, dkcl_ctrl and dkcl_dp.

// Each input item is a key of four 64-bit masks; each one produces exactly one
// result item: the slot holding an equal key and an outcome code (recent-list
// hit, table hit, newly allocated, or full with slot 0). One item is processed
// at a time. Steps per item: accept, then for each recent-list entry a check,
// followed by a key store read and compare if the entry is valid, then a read
// and compare per valid table slot scanned, on a miss an end-of-scan step and
// an allocate step, and last the hand-off, which is held for as long as the
// previous result still waits in the output register under a receiver stall.
// The key store has a single registered read port, so each table slot scanned
// takes a read and then a compare. Slots are never freed and are filled lowest
// first, so slot validity is a fill count and no clearing pass runs after
// reset. The result sits in an output register; a new item is accepted while
// it still waits to be taken.
module descriptor_key_cache_lookup_top
	import dkcl_pkg::*;
#(
	parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
	parameter int RECENT_DEPTH = RECENT_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [MASK_W-1:0]    mask_full,
	input  logic [MASK_W-1:0]    mask_multistream,
	input  logic [MASK_W-1:0]    mask_interleaved,
	input  logic [MASK_W-1:0]    mask_instanced,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SLOT_W-1:0]    slot,
	output logic [OUTCOME_W-1:0] outcome
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: accept, recent walk, table scan, allocate, hand-off
	dkcl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and compare
	dkcl_dp #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.RECENT_DEPTH (RECENT_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.mask_full        (mask_full),
		.mask_multistream (mask_multistream),
		.mask_interleaved (mask_interleaved),
		.mask_instanced   (mask_instanced),
		.cmd              (cmd),
		.sts              (sts),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.slot             (slot),
		.outcome          (outcome)
	);

endmodule
